>>> rtl/u2a_pkg.sv
// shared types, constants and helpers for the unsigned to ascii digit converter
// no dependencies
`timescale 1ns / 1ps

package u2a_pkg;

  // width of the value field
  localparam int VALUE_WIDTH = 32;
  localparam int VALUE_BITS_DEFAULT = 32;

  // ascii bases for digit encoding
  localparam logic [6:0] CHAR_ZERO = 7'h30;
  localparam logic [6:0] CHAR_ALPHA_BASE = 7'h37;  // 'A' - 10
  localparam logic [3:0] DEC_RADIX = 4'd10;

  // radix select
  localparam logic MODE_DEC = 1'b0;
  localparam logic MODE_HEX = 1'b1;

  // digit cell operations
  typedef logic [1:0] cell_op_t;
  localparam cell_op_t CELL_HOLD   = 2'd0;
  localparam cell_op_t CELL_LOAD   = 2'd1;
  localparam cell_op_t CELL_DABBLE = 2'd2;
  localparam cell_op_t CELL_SHIFT  = 2'd3;

  typedef struct packed {
    cell_op_t op;
  } cell_ctrl_t;

  function automatic logic [6:0] digit_char(input logic [3:0] d);
    logic [6:0] base;
    base = (d < DEC_RADIX) ? CHAR_ZERO : CHAR_ALPHA_BASE;
    return base + {3'b000, d};
  endfunction

endpackage

>>> rtl/u2a_cell.sv
// one digit cell of the converter chain: holds a 4-bit digit
// depends on u2a_pkg
`timescale 1ns / 1ps

module u2a_cell (
  input  logic               clk,
  input  u2a_pkg::cell_ctrl_t ctrl,
  input  logic [3:0]         load_digit,
  input  logic               carry_in,
  input  logic [3:0]         neighbor_digit,
  output logic               carry_out,
  output logic [3:0]         digit
);

  logic [3:0] adjusted;
  logic [3:0] digit_next;

  // add 3 before the shift when the digit would overflow past nine
  assign adjusted  = (digit >= 4'd5) ? digit + 4'd3 : digit;
  assign carry_out = adjusted[3];

  always_comb begin
    case (ctrl.op)
      u2a_pkg::CELL_LOAD:   digit_next = load_digit;
      u2a_pkg::CELL_DABBLE: digit_next = {adjusted[2:0], carry_in};
      u2a_pkg::CELL_SHIFT:  digit_next = neighbor_digit;
      default:              digit_next = digit;
    endcase
  end

  always_ff @(posedge clk) begin
    digit <= digit_next;
  end

endmodule

>>> rtl/unsigned_to_ascii_digits.sv
// top level of the unsigned to ascii digit converter: control, digit chain, output register
// depends on u2a_pkg and u2a_cell
// sequence: load the word, then a bit-serial shift-and-add pass over min(VALUE_BITS,32) bits in decimal mode
//   (none in hex mode), then scan out the chain one digit cell at a time, held while out_ready is low
// throughput: one word at a time, a new word is taken only once the last has been scanned out
// reset: synchronous, clears the control state and the output valid flag
`timescale 1ns / 1ps

module unsigned_to_ascii_digits #(
  parameter int VALUE_BITS = u2a_pkg::VALUE_BITS_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [u2a_pkg::VALUE_WIDTH-1:0] value,
  input  logic        mode,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [6:0]  character,
  output logic        last
);

  localparam int CONV_BITS = (VALUE_BITS < u2a_pkg::VALUE_WIDTH) ? VALUE_BITS
                                                                  : u2a_pkg::VALUE_WIDTH;
  // decimal digit count of the widest value: floor(bits * log10 2) + 1
  localparam int NCELLS = ((CONV_BITS * 1233) >> 12) + 1;
  localparam int BCNT_W = $clog2(CONV_BITS + 1);
  localparam int RCNT_W = $clog2(NCELLS + 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CONV = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  logic [1:0]            state;
  logic [CONV_BITS-1:0]  shreg;
  logic [BCNT_W-1:0]     bit_cnt;
  logic [RCNT_W-1:0]     remaining;
  logic                  started;

  logic [NCELLS*4-1:0]   padded;
  logic [3:0]            digits  [NCELLS];
  logic                  carries [NCELLS];
  u2a_pkg::cell_ctrl_t   cell_ctrl;
  logic                  accept;
  logic                  advance;
  logic                  emit;
  logic [3:0]            top_digit;

  assign in_ready  = (state == ST_IDLE);
  assign accept    = in_valid && in_ready;
  assign padded    = (NCELLS*4)'(value[CONV_BITS-1:0]);
  assign top_digit = digits[NCELLS-1];
  assign advance   = (state == ST_EMIT) && (!out_valid || out_ready);
  // skip leading zeros, but always show the ones digit
  assign emit      = advance && (top_digit != 4'd0 || started || remaining == RCNT_W'(1));

  always_comb begin
    cell_ctrl.op = u2a_pkg::CELL_HOLD;
    if (accept) begin
      cell_ctrl.op = u2a_pkg::CELL_LOAD;
    end else if (state == ST_CONV) begin
      cell_ctrl.op = u2a_pkg::CELL_DABBLE;
    end else if (advance) begin
      cell_ctrl.op = u2a_pkg::CELL_SHIFT;
    end
  end

  for (genvar i = 0; i < NCELLS; i++) begin : g_cell
    logic       cin;
    logic [3:0] nbr;
    logic [3:0] ld;
    if (i == 0) begin : g_first
      assign cin = shreg[CONV_BITS-1];
      assign nbr = 4'd0;
    end else begin : g_rest
      assign cin = carries[i-1];
      assign nbr = digits[i-1];
    end
    // hex digits are the nibbles themselves, decimal starts from zero
    assign ld = (mode == u2a_pkg::MODE_HEX) ? padded[i*4 +: 4] : 4'd0;

    u2a_cell u_cell (
      .clk            (clk),
      .ctrl           (cell_ctrl),
      .load_digit     (ld),
      .carry_in       (cin),
      .neighbor_digit (nbr),
      .carry_out      (carries[i]),
      .digit          (digits[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            state <= (mode == u2a_pkg::MODE_HEX) ? ST_EMIT : ST_CONV;
          end
        end
        ST_CONV: begin
          if (bit_cnt == BCNT_W'(1)) begin
            state <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (advance && remaining == RCNT_W'(1)) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      shreg     <= value[CONV_BITS-1:0];
      bit_cnt   <= BCNT_W'(CONV_BITS);
      remaining <= RCNT_W'(NCELLS);
      started   <= 1'b0;
    end else if (state == ST_CONV) begin
      shreg   <= {shreg[CONV_BITS-2:0], 1'b0};
      bit_cnt <= bit_cnt - BCNT_W'(1);
    end else if (advance) begin
      remaining <= remaining - RCNT_W'(1);
      if (emit) begin
        started <= 1'b1;
      end
    end
    if (emit) begin
      character <= u2a_pkg::digit_char(top_digit);
      last      <= (remaining == RCNT_W'(1));
    end
  end

endmodule

>>> rtl/u2a_checker.sv
// port-level checks for the unsigned to ascii digit converter, bound to the top level
// depends on unsigned_to_ascii_digits
`timescale 1ns / 1ps

module u2a_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [6:0]  character,
  input logic        last
);

  // a stalled output word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(character) && $stable(last))
    else $error("output word changed while stalled");

  // only digit codes leave the block
  a_char_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (character >= 7'h30 && character <= 7'h39) ||
                  (character >= 7'h41 && character <= 7'h46))
    else $error("character is not a digit code");

  // one word in flight at a time
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while converting");

  // reset leaves the block idle with nothing on the output
  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid && in_ready)
    else $error("block not idle after reset");

endmodule

bind unsigned_to_ascii_digits u2a_checker u_u2a_checker (.*);

>>> dv/tb_unsigned_to_ascii_digits.sv
// testbench for unsigned_to_ascii_digits: directed table then bursty random words,
// every digit checked in order against a typed string or a local radix conversion
// depends on u2a_pkg and the rtl of unsigned_to_ascii_digits
`timescale 1ns / 1ps

module tb_unsigned_to_ascii_digits;

  localparam int VB = 32;
  localparam int RANDOM_WORDS = 80;
  localparam int N_DIRECTED = 22;

  typedef struct packed {
    logic [6:0] ch;
    logic       lst;
  } digit_t;

  // want holds up to ten ascii chars right-justified, zero means compute it
  typedef struct packed {
    logic [31:0] v;
    logic        m;
    logic [79:0] want;
  } stim_row_t;

  localparam stim_row_t DIRECTED [N_DIRECTED] = '{
    '{32'd0,          u2a_pkg::MODE_DEC, 80'("0")},
    '{32'd0,          u2a_pkg::MODE_HEX, 80'("0")},
    '{32'd1,          u2a_pkg::MODE_DEC, 80'("1")},
    '{32'd1,          u2a_pkg::MODE_HEX, 80'("1")},
    '{32'd9,          u2a_pkg::MODE_DEC, 80'("9")},
    '{32'd10,         u2a_pkg::MODE_DEC, 80'("10")},
    '{32'd10,         u2a_pkg::MODE_HEX, 80'("A")},
    '{32'd15,         u2a_pkg::MODE_HEX, 80'("F")},
    '{32'd16,         u2a_pkg::MODE_HEX, 80'("10")},
    '{32'hFFFFFFFF,   u2a_pkg::MODE_DEC, 80'("4294967295")},
    '{32'hFFFFFFFF,   u2a_pkg::MODE_HEX, 80'("FFFFFFFF")},
    '{32'd999999999,  u2a_pkg::MODE_DEC, 80'("999999999")},
    '{32'd1000000000, u2a_pkg::MODE_DEC, 80'("1000000000")},
    '{32'h80000000,   u2a_pkg::MODE_HEX, 80'("80000000")},
    '{32'h12345678,   u2a_pkg::MODE_HEX, 80'("12345678")},
    '{32'h00ABCDEF,   u2a_pkg::MODE_HEX, 80'("ABCDEF")},
    '{32'h80000000,   u2a_pkg::MODE_DEC, 80'd0},
    '{32'hDEADBEEF,   u2a_pkg::MODE_DEC, 80'd0},
    '{32'h0F0F0F0F,   u2a_pkg::MODE_HEX, 80'd0},
    '{32'h5555AAAA,   u2a_pkg::MODE_DEC, 80'd0},
    '{32'hAAAA5555,   u2a_pkg::MODE_HEX, 80'd0},
    '{32'h7FFFFFFF,   u2a_pkg::MODE_DEC, 80'd0}
  };

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [31:0] value;
  logic        mode;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [6:0]  character;
  logic        last;

  digit_t pending_digits[$];
  digit_t got_digit;
  int     error_count = 0;
  int     rx_cycle = 0;
  int     rx_style = 0;

  unsigned_to_ascii_digits #(.VALUE_BITS(VB)) dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .value    (value),
    .mode     (mode),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .character(character),
    .last     (last)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("FAIL unsigned_to_ascii_digits");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    error_count++;
  endtask

  // queue one run of digits, flagging the final one
  task automatic push_digits(input logic [6:0] chars[$]);
    digit_t d;
    foreach (chars[i]) begin
      d.ch  = chars[i];
      d.lst = (i == chars.size() - 1);
      pending_digits.push_back(d);
    end
  endtask

  task automatic predict_digits(input logic [31:0] v_in, input logic m);
    logic [31:0] v;
    logic [31:0] mask;
    logic [3:0]  nib;
    logic        started;
    logic [6:0]  chars[$];
    mask = (VB >= 32) ? 32'hFFFFFFFF : ((32'd1 << VB) - 32'd1);
    v = v_in & mask;
    started = 1'b0;
    if (m == u2a_pkg::MODE_HEX) begin
      for (int sh = 28; sh >= 0; sh -= 4) begin
        nib = v[sh +: 4];
        if (nib != 4'd0 || started || sh == 0) begin
          started = 1'b1;
          chars.push_back((nib < 4'd10) ? 7'("0" + nib) : 7'("A" + nib - 10));
        end
      end
    end else if (v == 32'd0) begin
      chars.push_back(7'("0"));
    end else begin
      while (v != 32'd0) begin
        chars.push_front(7'("0" + v % 10));
        v = v / 10;
      end
    end
    push_digits(chars);
  endtask

  task automatic push_typed(input logic [79:0] want);
    logic [6:0] chars[$];
    for (int i = 9; i >= 0; i--)
      if (want[i*8 +: 8] != 8'd0) chars.push_back(want[i*8 +: 7]);
    push_digits(chars);
  endtask

  // hold the word until the block takes it
  task automatic send_word(input logic [31:0] v, input logic m);
    in_valid <= 1'b1;
    value    <= v;
    mode     <= m;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic drain_outputs();
    in_valid <= 1'b0;
    while (pending_digits.size() != 0) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_value();
    int     w;
    longint p;
    case ($urandom_range(0, 4))
      0: rand_value = $urandom;
      1: begin
        w = $urandom_range(1, 32);
        rand_value = $urandom & 32'((64'd1 << w) - 1);
      end
      2: rand_value = $urandom_range(0, 20);
      3: begin
        // around powers of ten, where the digit count changes
        p = 1;
        repeat ($urandom_range(0, 9)) p = p * 10;
        rand_value = 32'(p + $urandom_range(0, 2) - 1);
      end
      default: begin
        // around powers of sixteen
        w = 4 * $urandom_range(1, 8);
        rand_value = 32'((64'd1 << w) - $urandom_range(0, 1));
      end
    endcase
  endfunction

  // receiver stalls in styles redrawn at random by a free-running cycle counter
  always @(posedge clk) begin
    rx_cycle <= rx_cycle + 1;
    if (rx_cycle % 64 == 0) rx_style <= $urandom_range(0, 3);
    case (rx_style)
      0: out_ready <= 1'b1;
      1: out_ready <= 1'($urandom_range(0, 1));
      2: out_ready <= ($urandom_range(0, 7) != 0);
      default: out_ready <= rx_cycle[3];
    endcase
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (pending_digits.size() == 0) begin
        report_mismatch($sformatf("unexpected character %h last %b", character, last));
      end else begin
        got_digit = pending_digits.pop_front();
        if (character !== got_digit.ch)
          report_mismatch($sformatf("character %h, want %h", character, got_digit.ch));
        if (last !== got_digit.lst)
          report_mismatch($sformatf("last %b, want %b", last, got_digit.lst));
      end
    end
  end

  initial begin
    int burst_left;
    logic [31:0] v;
    logic m;
    rst      <= 1'b1;
    in_valid <= 1'b0;
    value    <= 32'd0;
    mode     <= u2a_pkg::MODE_DEC;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    foreach (DIRECTED[i]) begin
      send_word(DIRECTED[i].v, DIRECTED[i].m);
      if (DIRECTED[i].want != 80'd0) push_typed(DIRECTED[i].want);
      else predict_digits(DIRECTED[i].v, DIRECTED[i].m);
    end
    drain_outputs();
    @(posedge clk);

    burst_left = $urandom_range(1, 12);
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      v = rand_value();
      m = 1'($urandom_range(0, 1));
      send_word(v, m);
      predict_digits(v, m);
      if (n == RANDOM_WORDS / 2) begin
        drain_outputs();
        @(posedge clk);
      end else begin
        burst_left--;
        if (burst_left == 0) begin
          in_valid <= 1'b0;
          repeat ($urandom_range(1, 10)) @(posedge clk);
          burst_left = $urandom_range(1, 12);
        end
      end
    end

    drain_outputs();
    repeat (60) @(posedge clk);
    if (error_count == 0) begin
      $display("PASS unsigned_to_ascii_digits");
    end else begin
      $display("FAIL unsigned_to_ascii_digits");
    end
    $finish;
  end

endmodule
